// File: hdl/ghp_pkg.sv
// ============================================================================
// Generational handle pool package
// Types, sizes and codes shared by the handle pool core and its parts.
// ============================================================================
`default_nettype none

package ghp_pkg;

    // Pool size and the widths that follow from it.
    localparam int SLOTS   = 64;
    localparam int GEN_W   = 16;
    localparam int FIELD_W = 16;
    localparam int IDX_W   = $clog2(SLOTS + 1);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int STK_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Request codes.
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_FREE   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Request and response words.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [31:0]        handle_out;
        logic [FIELD_W-1:0] slot_out;
        logic [1:0]         status;
    } rsp_t;

    // One entry of the per-slot table.
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             live;
    } tbl_entry_t;

    // Write port of the per-slot table.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        tbl_entry_t       data;
    } tbl_wr_t;

    // One entry of the free stack: a slot and the generation it last carried.
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] slot;
    } stk_entry_t;

    // Free stack contents after reset: entry i holds slot SLOTS - i.
    function automatic stk_entry_t stack_init(input logic [STK_AW-1:0] addr);
        stk_entry_t e;
        e.gen  = '0;
        e.slot = IDX_W'(SLOTS - int'(addr));
        return e;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ghp_slot_table.sv
// ============================================================================
// Per-slot table
// Generation counter and live mark for every slot, one synchronous memory
// with a registered read; entries not yet written read as zero.
// ============================================================================
`default_nettype none

module ghp_slot_table (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [ghp_pkg::IDX_W-1:0]  rd_addr,
    output ghp_pkg::tbl_entry_t             rd_data,
    input  wire ghp_pkg::tbl_wr_t           wr
);

    ghp_pkg::tbl_entry_t mem [ghp_pkg::SLOTS+1];
    logic [ghp_pkg::SLOTS:0] written_reg;
    ghp_pkg::tbl_entry_t q_reg;
    logic hit_reg;

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Marks of entries that have been written since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr.en)
        begin
            written_reg[wr.addr] <= 1'b1;
        end
    end

    // Registered read, with the written mark captured alongside.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_reg   <= mem[rd_addr];
            hit_reg <= written_reg[rd_addr];
        end
    end

    // An entry never written reads as generation zero, not live.
    assign rd_data = hit_reg ? q_reg : '0;

endmodule

`default_nettype wire

// File: hdl/generational_handle_pool_core.sv
// ============================================================================
// Generational handle pool core
// Allocates, validates and frees generation-tagged slot handles.
// ============================================================================
//
// Channel   Direction  Word    Handshake
// req       in         req_t   req_valid / req_stall
// rsp       out        rsp_t   rsp_valid / rsp_stall
//
// Each request reads both the free stack and the slot table at the accepting
// edge, and modifies and writes back at the finishing edge, once the output
// register is free; the single-ported memories force that split.
// A request is accepted while a finished response waits in the output
// register; it then holds in the working stage until that register frees.
// Reset is asynchronous and needs no clearing pass: per-entry written marks
// give the reset contents of both memories.
// ============================================================================
`default_nettype none

module generational_handle_pool_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    input  wire ghp_pkg::req_t req,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    output ghp_pkg::rsp_t rsp
);

    localparam int IDX_W  = ghp_pkg::IDX_W;
    localparam int CNT_W  = ghp_pkg::CNT_W;
    localparam int STK_AW = ghp_pkg::STK_AW;
    localparam int GEN_W  = ghp_pkg::GEN_W;

    // Working stage and output register.
    logic              busy_reg;
    ghp_pkg::req_t     req_reg;
    logic              empty_reg;
    logic              in_range_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    ghp_pkg::rsp_t     rsp_reg;
    ghp_pkg::rsp_t     rsp_next;

    // Free stack memory.
    ghp_pkg::stk_entry_t stk_mem [ghp_pkg::SLOTS];
    logic [ghp_pkg::SLOTS-1:0] stk_written_reg;
    ghp_pkg::stk_entry_t stk_q_reg;
    logic                stk_hit_reg;
    logic [STK_AW-1:0]   stk_rd_addr_reg;
    ghp_pkg::stk_entry_t stk_top;
    logic                stk_we;
    logic [STK_AW-1:0]   stk_wr_addr;
    ghp_pkg::stk_entry_t stk_wr_data;

    // Slot table ports.
    logic                tbl_rd_en;
    logic [IDX_W-1:0]    tbl_rd_addr;
    ghp_pkg::tbl_entry_t tbl_rd;
    ghp_pkg::tbl_wr_t    tbl_wr;

    logic                accept;
    logic                out_free;
    logic                finish;
    logic                slot_ok;
    logic [CNT_W-1:0]    count_dec;
    logic [GEN_W-1:0]    gen_new;
    logic                handle_ok;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign finish    = busy_reg && out_free;
    assign req_stall = busy_reg;
    assign accept    = req_valid && !busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Address decode at acceptance.
    assign slot_ok   = (req.handle_in[15:0] != '0) &&
                       (req.handle_in[15:0] <= 16'(ghp_pkg::SLOTS));
    assign count_dec = count_reg - CNT_W'(1);

    assign tbl_rd_en   = accept;
    assign tbl_rd_addr = slot_ok ? req.handle_in[IDX_W-1:0] : '0;

    // Working stage capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (finish)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req;
            empty_reg    <= (count_reg == '0);
            in_range_reg <= slot_ok;
        end
    end

    // Free stack: registered read of the top entry at acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stk_q_reg       <= stk_mem[count_dec[STK_AW-1:0]];
            stk_hit_reg     <= stk_written_reg[count_dec[STK_AW-1:0]];
            stk_rd_addr_reg <= count_dec[STK_AW-1:0];
        end
    end

    assign stk_top = stk_hit_reg ? stk_q_reg : ghp_pkg::stack_init(stk_rd_addr_reg);

    // Free stack write port.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stk_written_reg <= '0;
        end
        else if (stk_we)
        begin
            stk_written_reg[stk_wr_addr] <= 1'b1;
        end
    end

    ghp_slot_table u_slot_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd),
        .wr      (tbl_wr)
    );

    // Modify and write back; build the response.
    assign gen_new   = stk_top.gen + GEN_W'(1);
    assign handle_ok = in_range_reg && tbl_rd.live &&
                       (tbl_rd.gen == req_reg.handle_in[31:16]);

    always_comb
    begin
        count_next       = count_reg;
        rsp_next         = '0;
        rsp_next.status  = ghp_pkg::ST_INVALID;
        stk_we           = 1'b0;
        stk_wr_addr      = count_reg[STK_AW-1:0];
        stk_wr_data      = '0;
        tbl_wr           = '0;

        unique case (req_reg.req_type)
            ghp_pkg::REQ_ALLOC:
            begin
                if (empty_reg)
                begin
                    rsp_next.status = ghp_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next          = count_dec;
                    tbl_wr.en           = finish;
                    tbl_wr.addr         = stk_top.slot;
                    tbl_wr.data.gen     = gen_new;
                    tbl_wr.data.live    = 1'b1;
                    rsp_next.handle_out = {gen_new, 16'(stk_top.slot)};
                    rsp_next.slot_out   = 16'(stk_top.slot);
                    rsp_next.status     = ghp_pkg::ST_OK;
                end
            end
            ghp_pkg::REQ_LOOKUP:
            begin
                if (handle_ok)
                begin
                    rsp_next.slot_out = req_reg.handle_in[15:0];
                    rsp_next.status   = ghp_pkg::ST_OK;
                end
            end
            ghp_pkg::REQ_FREE:
            begin
                if (handle_ok)
                begin
                    tbl_wr.en        = finish;
                    tbl_wr.addr      = req_reg.handle_in[IDX_W-1:0];
                    tbl_wr.data.gen  = tbl_rd.gen;
                    tbl_wr.data.live = 1'b0;
                    // A full stack cannot occur here; the push is dropped if it does.
                    if (count_reg < CNT_W'(ghp_pkg::SLOTS))
                    begin
                        stk_we           = finish;
                        stk_wr_data.gen  = tbl_rd.gen;
                        stk_wr_data.slot = req_reg.handle_in[IDX_W-1:0];
                        count_next       = count_reg + CNT_W'(1);
                    end
                    rsp_next.slot_out = req_reg.handle_in[15:0];
                    rsp_next.status   = ghp_pkg::ST_OK;
                end
            end
            default:
            begin
                rsp_next.status = ghp_pkg::ST_INVALID;
            end
        endcase
    end

    // Stack count and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CNT_W'(ghp_pkg::SLOTS);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ghp_checker.sv
// ============================================================================
// Handle pool port checker
// Assertions on what the handle pool core shows at its ports.
// ============================================================================
`default_nettype none

module ghp_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire ghp_pkg::rsp_t rsp
);

    // A response held by the receiver does not change.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // Each accepted request blocks acceptance in the cycle after it.
    a_req_gap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted on two consecutive cycles");

    // An error response carries no handle and no slot.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ghp_pkg::ST_OK) |->
            (rsp.handle_out == '0) && (rsp.slot_out == '0))
        else $error("error response with nonzero handle or slot");

    // A new handle names the returned slot, and every returned slot lies in the pool.
    a_alloc_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ghp_pkg::ST_OK) && (rsp.handle_out != '0) |->
            (rsp.handle_out[15:0] == rsp.slot_out))
        else $error("allocated handle does not match its slot");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ghp_pkg::ST_OK) |->
            (rsp.slot_out != '0) && (rsp.slot_out <= 16'(ghp_pkg::SLOTS)))
        else $error("returned slot outside the pool");

endmodule

bind generational_handle_pool_core ghp_checker u_ghp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// File: tb/tb_generational_handle_pool_core.sv
`timescale 1ns / 100ps
// ============================================================================
// Generational handle pool core testbench
// Drives allocate, lookup and free requests into the pool and checks every
// response word against a cycle-free model kept in the bench or a typed row's own answer.
// A directed table covers the corner handles first. The pool is then drained
// to empty, one slot is cycled through allocate and free with no idling on
// either side, and a long random mix of valid, stale and malformed handles
// follows. Both channels idle at random.
// ============================================================================

module tb_generational_handle_pool_core;

    // Undefined request code; the pool answers it as invalid.
    localparam logic [1:0] REQ_UNDEF = 2'd3;

    localparam int IDLE_PCT     = 19;
    localparam int RANDOM_ITEMS = 930;
    localparam int BURST_ROUNDS = 64;
    localparam int DRAIN_CYCLES = 16;
    // About 1150 words, with idling and stalls on both sides, fit well within the limit.
    localparam int CYCLE_LIMIT  = 100000;

    // One row of the directed table; typed rows carry their own answer.
    typedef struct packed {
        ghp_pkg::req_t w;
        logic          typed;
        ghp_pkg::rsp_t rsp;
    } dir_row_t;

    localparam ghp_pkg::rsp_t NO_RSP = '0;
    localparam int   DIR_ROWS = 24;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{ghp_pkg::REQ_ALLOC,  32'h0000_0000}, 1'b1, '{32'h0001_0001, 16'd1, ghp_pkg::ST_OK}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0001_0001}, 1'b1, '{32'h0000_0000, 16'd1, ghp_pkg::ST_OK}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0000_0000}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0001_0000}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0001_0041}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'hFFFF_FFFF}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0000_0001}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0001_0002}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{REQ_UNDEF,           32'h0001_0001}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_FREE,   32'h0001_0002}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_FREE,   32'hFFFF_0001}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_FREE,   32'h0001_0001}, 1'b1, '{32'h0000_0000, 16'd1, ghp_pkg::ST_OK}},
        '{'{ghp_pkg::REQ_FREE,   32'h0001_0001}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0001_0001}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_ALLOC,  32'h0000_0000}, 1'b1, '{32'h0002_0001, 16'd1, ghp_pkg::ST_OK}},
        '{'{ghp_pkg::REQ_ALLOC,  32'hFFFF_FFFF}, 1'b0, NO_RSP},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0001_0002}, 1'b0, NO_RSP},
        '{'{ghp_pkg::REQ_FREE,   32'h0002_0001}, 1'b1, '{32'h0000_0000, 16'd1, ghp_pkg::ST_OK}},
        '{'{ghp_pkg::REQ_FREE,   32'h0001_0002}, 1'b1, '{32'h0000_0000, 16'd2, ghp_pkg::ST_OK}},
        '{'{REQ_UNDEF,           32'h0000_0000}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0001_FFFF}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_FREE,   32'h0000_0000}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0001_0040}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}},
        '{'{ghp_pkg::REQ_LOOKUP, 32'h0000_0040}, 1'b1, '{'0, 16'd0, ghp_pkg::ST_INVALID}}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    ghp_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    ghp_pkg::rsp_t rsp;

    // Model of the pool: free stack, its depth, and per-slot tags.
    logic [15:0]               pool_stack [ghp_pkg::SLOTS];
    int                        pool_depth;
    logic [ghp_pkg::GEN_W-1:0] slot_gen   [ghp_pkg::SLOTS+1];
    bit                        slot_live  [ghp_pkg::SLOTS+1];

    ghp_pkg::rsp_t pending_rsp [$];
    int   err_count   = 0;
    int   cycle_count = 0;
    bit   quiet       = 1'b0;

    generational_handle_pool_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Pool contents right after reset: slot 1 on top, nothing live.
    function automatic void pool_reset();
        for (int i = 0; i < ghp_pkg::SLOTS; i++)
            pool_stack[i] = 16'(ghp_pkg::SLOTS - i);
        pool_depth = ghp_pkg::SLOTS;
        for (int i = 0; i <= ghp_pkg::SLOTS; i++)
        begin
            slot_gen[i]  = '0;
            slot_live[i] = 1'b0;
        end
    endfunction

    // Applies one request word to the model and returns its response word.
    function automatic ghp_pkg::rsp_t pool_step(input ghp_pkg::req_t w);
        ghp_pkg::rsp_t r;
        logic [15:0]   s;
        logic [15:0]   g;
        bit            valid_handle;
        r        = '0;
        r.status = ghp_pkg::ST_INVALID;
        s        = w.handle_in[15:0];
        g        = w.handle_in[31:16];
        valid_handle = (s != 16'd0) && (int'(s) <= ghp_pkg::SLOTS) && slot_live[s]
                       && (slot_gen[s] == g);
        case (w.req_type)
            ghp_pkg::REQ_ALLOC:
            begin
                if (pool_depth == 0)
                    r.status = ghp_pkg::ST_EMPTY;
                else
                begin
                    pool_depth--;
                    s = pool_stack[pool_depth];
                    slot_gen[s]  = slot_gen[s] + 16'd1;
                    slot_live[s] = 1'b1;
                    r.handle_out = {slot_gen[s], s};
                    r.slot_out   = s;
                    r.status     = ghp_pkg::ST_OK;
                end
            end
            ghp_pkg::REQ_LOOKUP:
            begin
                if (valid_handle)
                begin
                    r.slot_out = s;
                    r.status   = ghp_pkg::ST_OK;
                end
            end
            ghp_pkg::REQ_FREE:
            begin
                if (valid_handle)
                begin
                    slot_live[s] = 1'b0;
                    if (pool_depth < ghp_pkg::SLOTS)
                    begin
                        pool_stack[pool_depth] = s;
                        pool_depth++;
                    end
                    r.slot_out = s;
                    r.status   = ghp_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offers one request word, starting and ending at a falling edge. The
    // expected response is queued at the accepting edge.
    task automatic send_word(input ghp_pkg::req_t w, input bit typed,
                             input ghp_pkg::rsp_t typed_rsp, output ghp_pkg::rsp_t pred);
        while (!quiet && ($urandom_range(99) < IDLE_PCT))
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        pred = pool_step(w);
        pending_rsp.push_back(typed ? typed_rsp : pred);
        @(negedge clk);
    endtask

    // Holds the request side until every queued response has come back.
    task automatic wait_for_responses();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Response side stalls at random except during quiet stretches.
    always @(negedge clk)
        rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

    // Compares every accepted response word with the oldest expectation.
    always @(posedge clk)
    begin
        ghp_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response: handle %h slot %0d status %0d",
                         $time, rsp.handle_out, rsp.slot_out, rsp.status);
                err_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp !== want)
                begin
                    $display("%0t: mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                             $time, want.handle_out, want.slot_out, want.status,
                             rsp.handle_out, rsp.slot_out, rsp.status);
                    err_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        ghp_pkg::req_t w;
        ghp_pkg::rsp_t pred;
        int            alloc_pct;
        int            live_slots [$];
        int            s;
        int            pick;
        pool_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corner cases.
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(DIR_TABLE[i].w, DIR_TABLE[i].typed, DIR_TABLE[i].rsp, pred);

        // Allocate every slot, then ask twice more from the empty pool, then
        // exercise the top slot number.
        w = '0;
        w.req_type = ghp_pkg::REQ_ALLOC;
        repeat (ghp_pkg::SLOTS + 2)
            send_word(w, 1'b0, NO_RSP, pred);
        w.handle_in = {16'd1, 16'(ghp_pkg::SLOTS)};
        w.req_type  = ghp_pkg::REQ_LOOKUP;
        send_word(w, 1'b0, NO_RSP, pred);
        w.req_type  = ghp_pkg::REQ_FREE;
        send_word(w, 1'b0, NO_RSP, pred);
        w.req_type  = ghp_pkg::REQ_LOOKUP;
        send_word(w, 1'b0, NO_RSP, pred);
        wait_for_responses();

        // Cycle the slot on top of the stack through allocate and free,
        // with both sides running flat out.
        quiet = 1'b1;
        for (int n = 0; n < BURST_ROUNDS; n++)
        begin
            w = '0;
            w.req_type = ghp_pkg::REQ_ALLOC;
            send_word(w, 1'b0, NO_RSP, pred);
            w.req_type  = ghp_pkg::REQ_FREE;
            w.handle_in = pred.handle_out;
            send_word(w, 1'b0, NO_RSP, pred);
        end
        quiet = 1'b0;

        // Random mix, mostly well-formed handles. The allocate share moves
        // between blocks so the pool swings between full and empty.
        alloc_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                case ($urandom_range(2))
                    0:       alloc_pct = 15;
                    1:       alloc_pct = 50;
                    default: alloc_pct = 85;
                endcase
            end
            live_slots.delete();
            for (int k = 1; k <= ghp_pkg::SLOTS; k++)
                if (slot_live[k])
                    live_slots.push_back(k);
            w = '0;
            w.handle_in = $urandom;
            pick = $urandom_range(99);
            if (int'($urandom_range(99)) < alloc_pct)
                w.req_type = ghp_pkg::REQ_ALLOC;
            else if (pick < 65)
            begin
                // Free or look up a live handle.
                if (live_slots.size() == 0)
                    w.req_type = ghp_pkg::REQ_ALLOC;
                else
                begin
                    s = live_slots[$urandom_range(live_slots.size() - 1)];
                    w.req_type  = (pick < 35) ? ghp_pkg::REQ_FREE : ghp_pkg::REQ_LOOKUP;
                    w.handle_in = {slot_gen[s], 16'(s)};
                end
            end
            else if (pick < 80)
            begin
                // Stale handle: a dead slot with its last generation, or a
                // live slot with the wrong one.
                s = $urandom_range(1, ghp_pkg::SLOTS);
                w.handle_in = {slot_gen[s], 16'(s)};
                if (slot_live[s])
                    w.handle_in[31:16] = slot_gen[s] + 16'($urandom_range(1, 16'hFFFF));
                w.req_type = $urandom_range(1) ? ghp_pkg::REQ_LOOKUP : ghp_pkg::REQ_FREE;
            end
            else if (pick < 92)
            begin
                // Malformed handle, often with a slot number at a bound.
                case ($urandom_range(4))
                    0:       w.handle_in[15:0] = 16'd0;
                    1:       w.handle_in[15:0] = 16'(ghp_pkg::SLOTS);
                    2:       w.handle_in[15:0] = 16'(ghp_pkg::SLOTS + 1);
                    3:       w.handle_in[15:0] = 16'hFFFF;
                    default: ;
                endcase
                w.req_type = $urandom_range(1) ? ghp_pkg::REQ_LOOKUP : ghp_pkg::REQ_FREE;
            end
            else
            begin
                // Undefined code, sometimes carrying a live handle.
                w.req_type = REQ_UNDEF;
                if (live_slots.size() != 0 && $urandom_range(1))
                begin
                    s = live_slots[$urandom_range(live_slots.size() - 1)];
                    w.handle_in = {slot_gen[s], 16'(s)};
                end
            end
            send_word(w, 1'b0, NO_RSP, pred);
        end

        wait_for_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: generational_handle_pool_core.f
hdl/ghp_pkg.sv
hdl/ghp_slot_table.sv
hdl/generational_handle_pool_core.sv
hdl/ghp_checker.sv
tb/tb_generational_handle_pool_core.sv
